// ===== rtl/ifbsf_pkg.sv =====
package ifbsf_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [BYTE_W-1:0] LINE_FLAG   = 8'h7E;
    localparam logic [BYTE_W-1:0] LINE_ESC    = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_OF_FLAG = 8'h5E;
    localparam logic [BYTE_W-1:0] ESC_OF_ESC  = 8'h5D;
    localparam logic [BYTE_W-1:0] ADDR_RESET  = 8'h03;
    localparam logic [BYTE_W-1:0] CTRL_SEQ0   = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_SEQ1   = 8'h40;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEQUENCE_BIT  = 2'd1;

    // One classified payload beat, as handed from front to back.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              data_esc;
        logic [BYTE_W-1:0] bcc2;
        logic              bcc2_esc;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] ctrl;
        logic              first;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic needs_esc(input logic [BYTE_W-1:0] b);
        needs_esc = (b == LINE_FLAG) || (b == LINE_ESC);
    endfunction

    function automatic logic [BYTE_W-1:0] esc_code(input logic [BYTE_W-1:0] b);
        esc_code = (b == LINE_FLAG) ? ESC_OF_FLAG : ESC_OF_ESC;
    endfunction

endpackage

// ===== rtl/ifbsf_front.sv =====
module ifbsf_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ifbsf_pkg::BYTE_W-1:0]          s_payload_byte,
    input  logic                                  s_first_byte,
    input  logic                                  s_last_byte,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ifbsf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ifbsf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  ifbsf_pkg::q_status_t                  q_status,
    output logic                                  q_push,
    output ifbsf_pkg::cmd_t                       q_cmd
);
    import ifbsf_pkg::*;

    logic [BYTE_W-1:0] addr_reg, addr_next;
    logic              seq_reg, seq_next;
    logic [BYTE_W-1:0] parity_reg, parity_next;
    logic [BYTE_W-1:0] parity_new;
    logic [BYTE_W-1:0] ctrl;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_status.full;
    assign q_push    = s_valid && s_ready;

    assign ctrl       = seq_reg ? CTRL_SEQ1 : CTRL_SEQ0;
    assign parity_new = (s_first_byte ? '0 : parity_reg) ^ s_payload_byte;

    always_comb begin
        q_cmd.data     = s_payload_byte;
        q_cmd.data_esc = needs_esc(s_payload_byte);
        q_cmd.bcc2     = parity_new;
        q_cmd.bcc2_esc = needs_esc(parity_new);
        q_cmd.addr     = addr_reg;
        q_cmd.ctrl     = ctrl;
        q_cmd.first    = s_first_byte;
        q_cmd.last     = s_last_byte;
    end

    always_comb begin
        parity_next = parity_reg;
        if (q_push) begin
            parity_next = s_last_byte ? '0 : parity_new;
        end
    end

    always_comb begin
        addr_next = addr_reg;
        seq_next  = seq_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FRAME_ADDRESS) begin
                addr_next = cfg_data[BYTE_W-1:0];
            end else if (cfg_index == REG_SEQUENCE_BIT) begin
                seq_next = cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg   <= ADDR_RESET;
            seq_reg    <= 1'b0;
            parity_reg <= '0;
        end else begin
            addr_reg   <= addr_next;
            seq_reg    <= seq_next;
            parity_reg <= parity_next;
        end
    end

endmodule

// ===== rtl/ifbsf_queue.sv =====
module ifbsf_queue #(
    parameter int unsigned DEPTH = ifbsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ifbsf_pkg::cmd_t       push_cmd,
    input  logic                  pop,
    output ifbsf_pkg::cmd_t       head_cmd,
    output ifbsf_pkg::q_status_t  status
);
    import ifbsf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/ifbsf_back.sv =====
module ifbsf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ifbsf_pkg::cmd_t               head_cmd,
    input  ifbsf_pkg::q_status_t          q_status,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ifbsf_pkg::BYTE_W-1:0]  m_line_byte,
    output logic                          m_run_end,
    output logic                          m_frame_end
);
    import ifbsf_pkg::*;

    typedef enum logic [8:0] {
        ST_OPEN     = 9'b000000001,
        ST_ADDR     = 9'b000000010,
        ST_CTRL     = 9'b000000100,
        ST_BCC1     = 9'b000001000,
        ST_DATA     = 9'b000010000,
        ST_DATA_ESC = 9'b000100000,
        ST_BCC2     = 9'b001000000,
        ST_BCC2_ESC = 9'b010000000,
        ST_CLOSE    = 9'b100000000
    } phase_t;

    phase_t            phase_reg, phase_next, phase_eff, phase_adv;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              run_end_reg, frame_end_reg;
    logic [BYTE_W-1:0] byte_out;
    logic              run_end_out, frame_end_out;
    logic              load;

    // a beat with no header starts straight at its data byte
    assign phase_eff = (phase_reg == ST_OPEN && !head_cmd.first) ? ST_DATA : phase_reg;

    always_comb begin
        byte_out      = LINE_FLAG;
        run_end_out   = 1'b0;
        frame_end_out = 1'b0;
        phase_adv     = ST_OPEN;
        unique case (phase_eff)
            ST_OPEN: begin
                byte_out  = LINE_FLAG;
                phase_adv = ST_ADDR;
            end
            ST_ADDR: begin
                byte_out  = head_cmd.addr;
                phase_adv = ST_CTRL;
            end
            ST_CTRL: begin
                byte_out  = head_cmd.ctrl;
                phase_adv = ST_BCC1;
            end
            ST_BCC1: begin
                byte_out  = head_cmd.addr ^ head_cmd.ctrl;
                phase_adv = ST_DATA;
            end
            ST_DATA: begin
                if (head_cmd.data_esc) begin
                    byte_out  = LINE_ESC;
                    phase_adv = ST_DATA_ESC;
                end else begin
                    byte_out    = head_cmd.data;
                    phase_adv   = head_cmd.last ? ST_BCC2 : ST_OPEN;
                    run_end_out = !head_cmd.last;
                end
            end
            ST_DATA_ESC: begin
                byte_out    = esc_code(head_cmd.data);
                phase_adv   = head_cmd.last ? ST_BCC2 : ST_OPEN;
                run_end_out = !head_cmd.last;
            end
            ST_BCC2: begin
                if (head_cmd.bcc2_esc) begin
                    byte_out  = LINE_ESC;
                    phase_adv = ST_BCC2_ESC;
                end else begin
                    byte_out  = head_cmd.bcc2;
                    phase_adv = ST_CLOSE;
                end
            end
            ST_BCC2_ESC: begin
                byte_out  = esc_code(head_cmd.bcc2);
                phase_adv = ST_CLOSE;
            end
            ST_CLOSE: begin
                byte_out      = LINE_FLAG;
                phase_adv     = ST_OPEN;
                run_end_out   = 1'b1;
                frame_end_out = 1'b1;
            end
            default: begin
                phase_adv = ST_OPEN;
            end
        endcase
    end

    assign load  = !q_status.empty && (!m_valid_reg || m_ready);
    assign q_pop = load && run_end_out;

    always_comb begin
        phase_next   = load ? phase_adv : phase_reg;
        m_valid_next = load ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= ST_OPEN;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg      <= byte_out;
            run_end_reg   <= run_end_out;
            frame_end_reg <= frame_end_out;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_line_byte = byte_reg;
    assign m_run_end   = run_end_reg;
    assign m_frame_end = frame_end_reg;

endmodule

// ===== rtl/info_frame_byte_stuffing_framer.sv =====
// Information frame framer with byte stuffing.
// s_ channel: one payload byte per beat, with first/last markers. A first
//   beat emits FLAG, address, control, BCC1 before its byte; a last beat is
//   followed by the stuffed BCC2 and a closing FLAG.
// m_ channel: one line byte per beat; m_run_end marks the last byte caused
//   by an input beat, m_frame_end the closing flag.
// cfg_ channel: index 0 frame address, index 1 sequence bit; other indexes
//   are dropped. Always ready; write only while the block is idle.
// Path: an accepted beat is written into the queue, and its first line byte
//   is then loaded into the output register once the beats ahead are out.
// Throughput: the output side emits one line byte per cycle while m_ready is
//   high, and an input beat causes 1 to 9 line bytes (1 or 2 for a mid-frame
//   byte). The front accepts one beat per cycle while the QUEUE_DEPTH-entry
//   queue has room.
// Reset: queue and output emptied, parity cleared, address 0x03, sequence 0.
// Stall: with m_ready low the output register holds; the queue fills and
//   then s_ready drops.
module info_frame_byte_stuffing_framer #(
    parameter int unsigned QUEUE_DEPTH = ifbsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ifbsf_pkg::BYTE_W-1:0]      s_payload_byte,
    input  logic                              s_first_byte,
    input  logic                              s_last_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ifbsf_pkg::BYTE_W-1:0]      m_line_byte,
    output logic                              m_run_end,
    output logic                              m_frame_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ifbsf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ifbsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ifbsf_pkg::*;

    q_status_t q_status;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    logic      q_push;
    logic      q_pop;

    ifbsf_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_first_byte   (s_first_byte),
        .s_last_byte    (s_last_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_cmd          (push_cmd)
    );

    ifbsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    ifbsf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_cmd    (head_cmd),
        .q_status    (q_status),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_line_byte (m_line_byte),
        .m_run_end   (m_run_end),
        .m_frame_end (m_frame_end)
    );

    a_close_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_end)
        else $error("closing flag without run end");

    a_close_is_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_line_byte == LINE_FLAG)
        else $error("closing byte is not a flag");

    a_esc_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_byte == LINE_ESC |-> !m_run_end)
        else $error("escape byte ends a run");

    a_pop_only_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import ifbsf_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BEATS  = 190;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              run_end;
        logic              frame_end;
    } line_beat_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_payload_byte;
    logic                   s_first_byte;
    logic                   s_last_byte;
    logic                   m_valid;
    logic                   m_ready;
    logic [BYTE_W-1:0]      m_line_byte;
    logic                   m_run_end;
    logic                   m_frame_end;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // framer state as the line should see it
    logic [BYTE_W-1:0] frame_addr = ADDR_RESET;
    logic              seq_bit    = 1'b0;
    logic [BYTE_W-1:0] bcc2_acc   = '0;

    line_beat_t line_bytes_due[$];
    line_beat_t run_buf[9];
    int         run_len;
    int         mismatch_cnt = 0;
    int         beats_sent   = 0;
    int         idle_cycles  = 0;
    int         stall_left   = 0;
    bit         calm         = 1'b0;

    info_frame_byte_stuffing_framer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_first_byte   (s_first_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_byte    (m_line_byte),
        .m_run_end      (m_run_end),
        .m_frame_end    (m_frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int gap_cycles();
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return LINE_FLAG;
            1: return LINE_ESC;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_line(input logic [BYTE_W-1:0] b);
        run_buf[run_len] = '{line_byte: b, run_end: 1'b0, frame_end: 1'b0};
        run_len++;
    endfunction

    function automatic void add_stuffed(input logic [BYTE_W-1:0] b);
        if (b == LINE_FLAG) begin
            add_line(LINE_ESC);
            add_line(ESC_OF_FLAG);
        end else if (b == LINE_ESC) begin
            add_line(LINE_ESC);
            add_line(ESC_OF_ESC);
        end else begin
            add_line(b);
        end
    endfunction

    // line bytes caused by one payload beat
    function automatic void frame_line_bytes(input logic [BYTE_W-1:0] data,
                                             input logic first, input logic last);
        logic [BYTE_W-1:0] ctrl;
        run_len = 0;
        if (first) begin
            ctrl = seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;
            add_line(LINE_FLAG);
            add_line(frame_addr);
            add_line(ctrl);
            add_line(frame_addr ^ ctrl);
            bcc2_acc = '0;
        end
        add_stuffed(data);
        bcc2_acc = bcc2_acc ^ data;
        if (last) begin
            add_stuffed(bcc2_acc);
            add_line(LINE_FLAG);
            run_buf[run_len-1].frame_end = 1'b1;
            bcc2_acc = '0;
        end
        run_buf[run_len-1].run_end = 1'b1;
        for (int i = 0; i < run_len; i++) line_bytes_due.push_back(run_buf[i]);
    endfunction

    // config, input and output beats, in that order
    always @(posedge aclk) begin
        line_beat_t got;
        line_beat_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_ADDRESS: frame_addr = cfg_data;
                    REG_SEQUENCE_BIT:  seq_bit = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                frame_line_bytes(s_payload_byte, s_first_byte, s_last_byte);
            if (m_valid && m_ready) begin
                got = '{line_byte: m_line_byte, run_end: m_run_end, frame_end: m_frame_end};
                if (line_bytes_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected line beat: byte %h run_end %b frame_end %b",
                                 got.line_byte, got.run_end, got.frame_end);
                end else begin
                    want = line_bytes_due.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("line beat mismatch: exp %h/%b/%b got %h/%b/%b",
                                     want.line_byte, want.run_end, want.frame_end,
                                     got.line_byte, got.run_end, got.frame_end);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left = gap_cycles() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        do begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end while (idle_cycles < STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // leaves s_valid high; settle() drops it
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic first,
                             input logic last);
        int gap;
        gap = (!calm && $urandom_range(0, 2) == 0) ? gap_cycles() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_payload_byte <= data;
        s_first_byte   <= first;
        s_last_byte    <= last;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (line_bytes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_config(input logic [BYTE_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] seq_word, input bit poke_spare);
        settle();
        write_reg(REG_FRAME_ADDRESS, addr);
        write_reg(REG_SEQUENCE_BIT, seq_word);
        if (poke_spare)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                      CFG_DATA_W'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_outside_frame();
        send_byte(8'h7E, 1'b0, 1'b0);
        send_byte(8'h7D, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_single_byte_frames();
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h7E, 1'b1, 1'b1);
        send_byte(8'h7D, 1'b1, 1'b1);
        send_byte(8'h3C, 1'b0, 1'b0);
    endtask

    task automatic test_header_not_stuffed();
        apply_config(LINE_FLAG, 8'h01, 1'b0);
        send_byte(8'h55, 1'b1, 1'b1);
        apply_config(LINE_ESC, 8'h00, 1'b0);
        send_byte(8'h7D, 1'b1, 1'b1);
        apply_config(8'h3E, 8'h01, 1'b0);
        send_byte(8'hA5, 1'b1, 1'b1);
    endtask

    task automatic test_multi_byte_frames();
        send_byte(8'h7D, 1'b1, 1'b0);
        send_byte(8'h7E, 1'b0, 1'b0);
        send_byte(8'h41, 1'b0, 1'b1);
        // restart mid-frame: old frame is abandoned
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(8'h56, 1'b1, 1'b0);
        send_byte(8'h78, 1'b0, 1'b1);
    endtask

    task automatic test_config_extremes();
        apply_config(8'h00, 8'hFF, 1'b1);
        send_byte(8'h81, 1'b1, 1'b1);
        apply_config(8'hFF, 8'hFE, 1'b1);
        send_byte(8'h18, 1'b1, 1'b1);
        apply_config(ADDR_RESET, 8'h01, 1'b1);
        send_byte(8'hC3, 1'b1, 1'b1);
    endtask

    task automatic test_random_frames();
        int start;
        int frames;
        int len;
        logic [BYTE_W-1:0] addr;
        start  = beats_sent;
        frames = 0;
        while (beats_sent - start < RANDOM_BEATS) begin
            calm = ($urandom_range(0, 5) == 0);
            if (frames % 16 == 15) begin
                case ($urandom_range(0, 4))
                    0: addr = 8'h00;
                    1: addr = 8'hFF;
                    2: addr = LINE_FLAG;
                    3: addr = LINE_ESC;
                    default: addr = BYTE_W'($urandom_range(0, 255));
                endcase
                apply_config(addr, CFG_DATA_W'($urandom_range(0, 255)),
                             $urandom_range(0, 2) == 0);
            end
            case ($urandom_range(0, 9))
                0: send_byte(rand_byte(), 1'b0, 1'($urandom_range(0, 1)));
                1: begin
                    // frame left open; the next first marker restarts it
                    len = $urandom_range(1, 4);
                    for (int i = 0; i < len; i++) send_byte(rand_byte(), i == 0, 1'b0);
                end
                default: begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        send_byte(rand_byte(), i == 0, i == len - 1);
                end
            endcase
            frames++;
        end
        calm = 1'b0;
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_payload_byte <= '0;
        s_first_byte   <= 1'b0;
        s_last_byte    <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_FRAME_ADDRESS;
        cfg_data       <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_outside_frame();
        test_single_byte_frames();
        test_header_not_stuffed();
        test_multi_byte_frames();
        test_config_extremes();
        test_random_frames();
        settle();

        if (mismatch_cnt == 0 && line_bytes_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
